[rtl/hrpf_pkg.sv]
`default_nettype none

package hrpf_pkg;

   // input item kinds
   typedef enum logic [1:0] {
      OP_COLOR = 2'd0,
      OP_PARAM = 2'd1,
      OP_BEGIN = 2'd2,
      OP_END   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_EMIT
   } state_type;

   // configuration register indexes
   localparam logic [1:0] CSR_BEGIN_CMD = 2'd0;
   localparam logic [1:0] CSR_END_CMD   = 2'd1;
   localparam logic [1:0] CSR_PARAM_CMD = 2'd2;

   localparam int         STORE_DEPTH = 56;
   localparam int         FILL_BITS   = 6;
   localparam int         ADDR_BITS   = 6;
   localparam int         IDX_BITS    = 6;

   localparam logic [FILL_BITS-1:0] STORE_FULL = FILL_BITS'(STORE_DEPTH);

   localparam logic [7:0] REPORT_ID = 8'h04;
   localparam logic [7:0] DATA_CMD  = 8'h12;

   // byte positions within a report
   localparam logic [IDX_BITS-1:0] BYTE_ID       = 6'd0;
   localparam logic [IDX_BITS-1:0] BYTE_CSUM_LO  = 6'd1;
   localparam logic [IDX_BITS-1:0] BYTE_CSUM_HI  = 6'd2;
   localparam logic [IDX_BITS-1:0] BYTE_CMD      = 6'd3;
   localparam logic [IDX_BITS-1:0] BYTE_SIZE     = 6'd4;
   localparam logic [IDX_BITS-1:0] BYTE_OFF_LO   = 6'd5;
   localparam logic [IDX_BITS-1:0] BYTE_OFF_MID  = 6'd6;
   localparam logic [IDX_BITS-1:0] BYTE_OFF_HI   = 6'd7;
   localparam logic [IDX_BITS-1:0] BYTE_PAYLOAD  = 6'd8;
   localparam logic [IDX_BITS-1:0] BYTE_LAST     = 6'd63;

   typedef struct packed {
      logic                accept;   // input transaction this cycle
      logic                sum_step; // add header byte idx into checksum
      logic                load;     // load byte idx into output register
      logic [IDX_BITS-1:0] idx;
      logic [IDX_BITS-1:0] nidx;     // idx for the next cycle
   } cmd_type;

   typedef struct packed {
      logic closes;    // current input item closes a report
      logic marker;    // current input item is begin or end
      logic out_free;  // output register can take a byte
   } status_type;

endpackage

`default_nettype wire

[rtl/hid_report_packet_framer_core.sv]
// Channel   Dir  Transfer               Payload
// req_      in   req_tvalid&req_tready  tdata: data_byte, pid; tuser: opcode; tlast: last_byte
// rsp_      out  rsp_tvalid&rsp_tready  tdata: report_byte, byte_index; tlast: report_end
// csr_      in   csr_valid&csr_ready    csr_index: register, csr_data: value (always ready)
//
// An item that closes nothing leaves the core idle and ready for the next one. A data or parameter report
// first adds the five header bytes into the checksum, one adder step each, then sends 64 byte transactions.
// A begin or end report skips the checksum step and sends 64 byte transactions.
// Bytes stream from a registered-read store, one per cycle while rsp_tready holds.
// Reset is synchronous; no clearing pass. Input is held off while a report is in flight.
`default_nettype none

module hid_report_packet_framer_core #(
   parameter int MAX_CHUNK   = 56,
   parameter int OFFSET_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // data_byte[7:0], pid[15:8]
   input  wire logic [1:0]  req_tuser,  // opcode[1:0]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // report_byte[7:0], byte_index[13:8], zero[15:14]
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   hrpf_pkg::cmd_type    cmd;
   hrpf_pkg::status_type status;

   assign csr_ready = 1'b1;

   hrpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hrpf_dp #(
      .MAX_CHUNK   (MAX_CHUNK),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_opcode    (req_tuser),
      .req_data_byte (req_tdata[7:0]),
      .req_pid       (req_tdata[15:8]),
      .req_last_byte (req_tlast),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

`default_nettype wire

[rtl/hrpf_ram.sv]
`default_nettype none

module hrpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 56
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/hrpf_ctrl.sv]
`default_nettype none

module hrpf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire hrpf_pkg::status_type   status,
   output hrpf_pkg::cmd_type           cmd
);

   hrpf_pkg::state_type                state_ff, state_in;
   logic [hrpf_pkg::IDX_BITS-1:0]      idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrpf_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      req_tready   = 1'b0;
      cmd.accept   = 1'b0;
      cmd.sum_step = 1'b0;
      cmd.load     = 1'b0;
      case (state_ff)
         hrpf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && status.closes) begin
               if (status.marker) begin
                  state_in = hrpf_pkg::ST_EMIT;
                  idx_in   = hrpf_pkg::BYTE_ID;
               end else begin
                  state_in = hrpf_pkg::ST_SUM;
                  idx_in   = hrpf_pkg::BYTE_CMD;
               end
            end
         end
         hrpf_pkg::ST_SUM: begin
            // header bytes 3..7 go into the checksum, payload is already in
            cmd.sum_step = 1'b1;
            if (idx_ff == hrpf_pkg::BYTE_OFF_HI) begin
               state_in = hrpf_pkg::ST_EMIT;
               idx_in   = hrpf_pkg::BYTE_ID;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         hrpf_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               idx_in   = idx_ff + 1'b1;
               if (idx_ff == hrpf_pkg::BYTE_LAST) begin
                  state_in = hrpf_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = hrpf_pkg::ST_IDLE;
         end
      endcase
      cmd.idx  = idx_ff;
      cmd.nidx = idx_in;
   end

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hrpf_pkg::ST_SUM) |->
         (idx_ff >= hrpf_pkg::BYTE_CMD && idx_ff <= hrpf_pkg::BYTE_OFF_HI))
      else $error("checksum phase outside header bytes");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && idx_ff == hrpf_pkg::BYTE_LAST) |=> (state_ff == hrpf_pkg::ST_IDLE))
      else $error("controller did not return to idle after last byte");

   a_no_load_outside_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == hrpf_pkg::ST_EMIT && !req_tready))
      else $error("byte loaded outside emit phase");

endmodule

`default_nettype wire

[rtl/hrpf_dp.sv]
`default_nettype none

module hrpf_dp #(
   parameter int MAX_CHUNK   = 56,
   parameter int OFFSET_BITS = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hrpf_pkg::cmd_type    cmd,
   output hrpf_pkg::status_type      status,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic [7:0]           req_pid,
   input  wire logic                 req_last_byte,
   input  wire logic                 csr_write,
   input  wire logic [1:0]           csr_index,
   input  wire logic [7:0]           csr_data,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output logic [15:0]               rsp_tdata,
   output logic                      rsp_tlast
);

   localparam int FB = hrpf_pkg::FILL_BITS;
   localparam logic [FB-1:0] MAX_FILL = FB'(MAX_CHUNK);

   function automatic logic [15:0] sext8(input logic [7:0] b);
      sext8 = {{8{b[7]}}, b};
   endfunction

   // configuration
   logic [7:0] begin_cmd_ff, end_cmd_ff, param_cmd_ff;

   // chunk state
   logic [FB-1:0]          fill_ff, fill_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [7:0]             pid_ff, pid_in;
   logic [15:0]            psum_ff, psum_in;

   // report being sent
   hrpf_pkg::op_type       kind_ff, kind_in;
   logic [FB-1:0]          size_ff, size_in;
   logic [OFFSET_BITS-1:0] roff_ff, roff_in;
   logic [15:0]            chk_ff, chk_in;

   // output register
   logic                   oval_ff, oval_in;
   logic [7:0]             obyte_ff;
   logic [hrpf_pkg::IDX_BITS-1:0] oidx_ff;
   logic                   olast_ff;

   hrpf_pkg::op_type       op;
   logic                   is_color, is_param, is_marker;
   logic                   store_en, closes;
   logic [FB-1:0]          fill_new;
   logic [15:0]            psum_new;
   logic [7:0]             rd_data;
   logic [hrpf_pkg::ADDR_BITS-1:0] rd_addr;
   logic [hrpf_pkg::IDX_BITS-1:0]  pay_idx;
   logic [23:0]            off24;
   logic [7:0]             cmd_byte, mark_cmd, rpt_byte;
   logic                   rpt_marker, rpt_color;

   assign op        = hrpf_pkg::op_type'(req_opcode);
   assign is_color  = (op == hrpf_pkg::OP_COLOR);
   assign is_param  = (op == hrpf_pkg::OP_PARAM);
   assign is_marker = !is_color && !is_param;

   assign store_en = (is_color && fill_ff < MAX_FILL) ||
                     (is_param && fill_ff < hrpf_pkg::STORE_FULL);
   assign fill_new = store_en ? fill_ff + 1'b1 : fill_ff;
   assign psum_new = store_en ? psum_ff + sext8(req_data_byte) : psum_ff;
   assign closes   = is_marker || (is_color && (fill_new >= MAX_FILL || req_last_byte)) ||
                     (is_param && req_last_byte);

   assign status.closes   = closes;
   assign status.marker   = is_marker;
   assign status.out_free = !oval_ff || rsp_tready;

   // registered read: address follows the index of the next cycle
   assign rd_addr = hrpf_pkg::ADDR_BITS'(cmd.nidx - hrpf_pkg::BYTE_PAYLOAD);

   hrpf_ram #(
      .WIDTH (8),
      .DEPTH (hrpf_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.accept && store_en),
      .wr_addr (hrpf_pkg::ADDR_BITS'(fill_ff)),
      .wr_data (req_data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // report byte for position cmd.idx
   always_comb begin
      rpt_marker = (kind_ff == hrpf_pkg::OP_BEGIN) || (kind_ff == hrpf_pkg::OP_END);
      rpt_color  = (kind_ff == hrpf_pkg::OP_COLOR);
      mark_cmd   = (kind_ff == hrpf_pkg::OP_BEGIN) ? begin_cmd_ff : end_cmd_ff;
      cmd_byte   = rpt_color ? hrpf_pkg::DATA_CMD : param_cmd_ff;
      off24      = 24'(roff_ff);
      pay_idx    = cmd.idx - hrpf_pkg::BYTE_PAYLOAD;
      rpt_byte   = 8'h00;
      if (cmd.idx == hrpf_pkg::BYTE_ID) begin
         rpt_byte = hrpf_pkg::REPORT_ID;
      end else if (cmd.idx == hrpf_pkg::BYTE_CSUM_LO) begin
         rpt_byte = rpt_marker ? mark_cmd : chk_ff[7:0];
      end else if (cmd.idx == hrpf_pkg::BYTE_CSUM_HI) begin
         rpt_byte = rpt_marker ? 8'h00 : chk_ff[15:8];
      end else if (cmd.idx == hrpf_pkg::BYTE_CMD) begin
         rpt_byte = rpt_marker ? mark_cmd : cmd_byte;
      end else if (!rpt_marker) begin
         if (cmd.idx == hrpf_pkg::BYTE_SIZE) begin
            rpt_byte = 8'(size_ff);
         end else if (cmd.idx == hrpf_pkg::BYTE_OFF_LO) begin
            rpt_byte = rpt_color ? off24[7:0] : pid_ff;
         end else if (cmd.idx == hrpf_pkg::BYTE_OFF_MID) begin
            rpt_byte = rpt_color ? off24[15:8] : 8'h00;
         end else if (cmd.idx == hrpf_pkg::BYTE_OFF_HI) begin
            rpt_byte = rpt_color ? off24[23:16] : 8'h00;
         end else if (pay_idx < hrpf_pkg::IDX_BITS'(size_ff)) begin
            rpt_byte = rd_data;
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      off_in  = off_ff;
      pid_in  = pid_ff;
      psum_in = psum_ff;
      kind_in = kind_ff;
      size_in = size_ff;
      roff_in = roff_ff;
      chk_in  = chk_ff;
      if (cmd.accept) begin
         if (is_param) begin
            pid_in = req_pid;
         end
         if (is_marker) begin
            kind_in = op;
         end else if (closes) begin
            kind_in = op;
            size_in = fill_new;
            roff_in = off_ff;
            chk_in  = psum_new;
            fill_in = '0;
            psum_in = '0;
            if (is_color) begin
               off_in = req_last_byte ? '0 : off_ff + OFFSET_BITS'(fill_new);
            end
         end else begin
            fill_in = fill_new;
            psum_in = psum_new;
         end
      end
      if (cmd.sum_step) begin
         chk_in = chk_ff + sext8(rpt_byte);
      end
   end

   assign oval_in = cmd.load || (oval_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         begin_cmd_ff <= 8'd1;
         end_cmd_ff   <= 8'd2;
         param_cmd_ff <= 8'd6;
         fill_ff      <= '0;
         off_ff       <= '0;
         pid_ff       <= '0;
         psum_ff      <= '0;
         oval_ff      <= 1'b0;
         kind_ff      <= hrpf_pkg::OP_COLOR;
      end else begin
         if (csr_write) begin
            case (csr_index)
               hrpf_pkg::CSR_BEGIN_CMD: begin_cmd_ff <= csr_data;
               hrpf_pkg::CSR_END_CMD:   end_cmd_ff   <= csr_data;
               hrpf_pkg::CSR_PARAM_CMD: param_cmd_ff <= csr_data;
               default: ;
            endcase
         end
         fill_ff <= fill_in;
         off_ff  <= off_in;
         pid_ff  <= pid_in;
         psum_ff <= psum_in;
         oval_ff <= oval_in;
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      roff_ff <= roff_in;
      chk_ff  <= chk_in;
      if (cmd.load) begin
         obyte_ff <= rpt_byte;
         oidx_ff  <= cmd.idx;
         olast_ff <= (cmd.idx == hrpf_pkg::BYTE_LAST);
      end
   end

   assign rsp_tvalid = oval_ff;
   assign rsp_tdata  = {2'b00, oidx_ff, obyte_ff};
   assign rsp_tlast  = olast_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!oval_ff || rsp_tready))
      else $error("output register overwritten while holding a byte");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= hrpf_pkg::STORE_FULL)
      else $error("fill count beyond store depth");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && closes && !is_marker) |=> (fill_ff == '0 && psum_ff == '0))
      else $error("store not emptied after closing item");

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   localparam int CHUNK_MAX  = 56;
   localparam int FRAME_LEN  = 64;
   localparam int SETTLE_CYC = 10;

   typedef struct packed {
      logic [7:0] val;
      logic [5:0] pos;
      logic       fin;
   } report_beat_type;

   // typed = 1: expected marker report given by exp_cmd instead of the predictor
   typedef struct packed {
      hrpf_pkg::op_type op;
      logic [7:0]       db;
      logic [7:0]       pid;
      logic             last;
      logic             typed;
      logic [7:0]       exp_cmd;
   } stim_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // data_byte[7:0], pid[15:8]
   logic [1:0]  req_tuser  = '0;   // opcode[1:0]
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // report_byte[7:0], byte_index[13:8], zero[15:14]
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [7:0]  csr_data   = '0;

   int src_idle_pct  = 23;
   int sink_idle_pct = 51;
   int fail_count    = 0;

   // predictor state
   logic [7:0]  chunk_store [hrpf_pkg::STORE_DEPTH];
   logic [5:0]  chunk_fill  = '0;
   logic [23:0] color_offset = '0;
   logic [7:0]  latched_pid = '0;
   logic [7:0]  cmd_begin   = 8'h01;
   logic [7:0]  cmd_end     = 8'h02;
   logic [7:0]  cmd_param   = 8'h06;

   logic [7:0]      frame_buf [FRAME_LEN];
   report_beat_type report_beat_q [$];

   stim_row_type directed_tbl [20] = '{
      '{hrpf_pkg::OP_BEGIN, 8'h00, 8'h00, 1'b0, 1'b1, 8'h01},
      '{hrpf_pkg::OP_END,   8'hFF, 8'hFF, 1'b1, 1'b1, 8'h02},
      '{hrpf_pkg::OP_COLOR, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00},  // one-byte chunk
      '{hrpf_pkg::OP_COLOR, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00},
      '{hrpf_pkg::OP_PARAM, 8'h80, 8'hFF, 1'b1, 1'b0, 8'h00},
      '{hrpf_pkg::OP_PARAM, 8'h7F, 8'h00, 1'b0, 1'b0, 8'h00},
      '{hrpf_pkg::OP_PARAM, 8'h01, 8'hA5, 1'b1, 1'b0, 8'h00},  // id of the last byte wins
      '{hrpf_pkg::OP_COLOR, 8'h55, 8'h0F, 1'b0, 1'b0, 8'h00},
      '{hrpf_pkg::OP_PARAM, 8'hAA, 8'h3C, 1'b1, 1'b0, 8'h00},  // mixed, closed as parameter
      '{hrpf_pkg::OP_PARAM, 8'h33, 8'h12, 1'b0, 1'b0, 8'h00},
      '{hrpf_pkg::OP_COLOR, 8'hCC, 8'hF0, 1'b1, 1'b0, 8'h00},  // mixed, closed as color
      '{hrpf_pkg::OP_COLOR, 8'h11, 8'h00, 1'b0, 1'b0, 8'h00},
      '{hrpf_pkg::OP_BEGIN, 8'h5A, 8'hC3, 1'b1, 1'b1, 8'h01},  // marker with bytes held
      '{hrpf_pkg::OP_END,   8'h00, 8'h00, 1'b0, 1'b1, 8'h02},
      '{hrpf_pkg::OP_COLOR, 8'h22, 8'h00, 1'b1, 1'b0, 8'h00},
      '{hrpf_pkg::OP_COLOR, 8'h80, 8'h00, 1'b0, 1'b0, 8'h00},
      '{hrpf_pkg::OP_COLOR, 8'h7F, 8'h00, 1'b1, 1'b0, 8'h00},
      '{hrpf_pkg::OP_PARAM, 8'hFF, 8'h80, 1'b1, 1'b0, 8'h00},
      '{hrpf_pkg::OP_END,   8'h00, 8'h00, 1'b0, 1'b1, 8'h02},
      '{hrpf_pkg::OP_BEGIN, 8'hFF, 8'hFF, 1'b0, 1'b1, 8'h01}
   };

   hid_report_packet_framer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial begin
      #5_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
   end

   task automatic clear_frame();
      int i;
      for (i = 0; i < FRAME_LEN; i++)
         frame_buf[i] = 8'h00;
      frame_buf[0] = hrpf_pkg::REPORT_ID;
   endtask

   task automatic queue_frame();
      int i;
      report_beat_type b;
      for (i = 0; i < FRAME_LEN; i++) begin
         b.val = frame_buf[i];
         b.pos = 6'(i);
         b.fin = (i == FRAME_LEN - 1);
         report_beat_q.push_back(b);
      end
   endtask

   // header is filled in; copies in the payload, adds the checksum, empties the chunk and queues the frame
   task automatic close_chunk();
      int i;
      logic [15:0] csum;
      csum = '0;
      for (i = 0; i < chunk_fill; i++)
         frame_buf[hrpf_pkg::BYTE_PAYLOAD + i] = chunk_store[i];
      for (i = hrpf_pkg::BYTE_CMD; i < FRAME_LEN; i++)
         csum = csum + {{8{frame_buf[i][7]}}, frame_buf[i]};
      frame_buf[hrpf_pkg::BYTE_CSUM_LO] = csum[7:0];
      frame_buf[hrpf_pkg::BYTE_CSUM_HI] = csum[15:8];
      chunk_fill = '0;
      queue_frame();
   endtask

   task automatic predict_report(input stim_row_type s);
      logic [7:0] cmd;
      clear_frame();
      case (s.op)
         hrpf_pkg::OP_COLOR: begin
            if (chunk_fill < CHUNK_MAX) begin
               chunk_store[chunk_fill] = s.db;
               chunk_fill = chunk_fill + 6'd1;
            end
            if (chunk_fill >= CHUNK_MAX || s.last) begin
               frame_buf[hrpf_pkg::BYTE_CMD]     = hrpf_pkg::DATA_CMD;
               frame_buf[hrpf_pkg::BYTE_SIZE]    = {2'b00, chunk_fill};
               frame_buf[hrpf_pkg::BYTE_OFF_LO]  = color_offset[7:0];
               frame_buf[hrpf_pkg::BYTE_OFF_MID] = color_offset[15:8];
               frame_buf[hrpf_pkg::BYTE_OFF_HI]  = color_offset[23:16];
               // end of the color array restarts the offset
               color_offset = s.last ? 24'd0 : color_offset + 24'(chunk_fill);
               close_chunk();
            end
         end
         hrpf_pkg::OP_PARAM: begin
            latched_pid = s.pid;
            if (chunk_fill < hrpf_pkg::STORE_DEPTH) begin
               chunk_store[chunk_fill] = s.db;
               chunk_fill = chunk_fill + 6'd1;
            end
            if (s.last) begin
               frame_buf[hrpf_pkg::BYTE_CMD]    = cmd_param;
               frame_buf[hrpf_pkg::BYTE_SIZE]   = {2'b00, chunk_fill};
               frame_buf[hrpf_pkg::BYTE_OFF_LO] = latched_pid;
               close_chunk();
            end
         end
         default: begin
            cmd = (s.op == hrpf_pkg::OP_BEGIN) ? cmd_begin : cmd_end;
            frame_buf[hrpf_pkg::BYTE_CSUM_LO] = cmd;
            frame_buf[hrpf_pkg::BYTE_CMD]     = cmd;
            queue_frame();
         end
      endcase
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input stim_row_type s);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s.pid, s.db};
      req_tuser  <= s.op;
      req_tlast  <= s.last;
      do
         @(posedge clock);
      while (!req_tready);
      if (s.typed) begin
         clear_frame();
         frame_buf[hrpf_pkg::BYTE_CSUM_LO] = s.exp_cmd;
         frame_buf[hrpf_pkg::BYTE_CMD]     = s.exp_cmd;
         queue_frame();
      end else begin
         predict_report(s);
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (report_beat_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      case (idx)
         hrpf_pkg::CSR_BEGIN_CMD: cmd_begin = value;
         hrpf_pkg::CSR_END_CMD:   cmd_end   = value;
         hrpf_pkg::CSR_PARAM_CMD: cmd_param = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_commands(input logic [7:0] b, input logic [7:0] e, input logic [7:0] p);
      write_csr(hrpf_pkg::CSR_BEGIN_CMD, b);
      write_csr(hrpf_pkg::CSR_END_CMD, e);
      write_csr(hrpf_pkg::CSR_PARAM_CMD, p);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed color arrays and parameters, plus markers and noise
   task automatic run_random(input int budget, input bit long_color, input bit long_param,
                             input bit hold_off);
      int sent, kind, len, n;
      stim_row_type s;
      sent = 0;
      while (sent < budget) begin
         if (sent == 0 && long_color) begin
            kind = 0;
            len  = $urandom_range(57, 62);
         end else if (sent == 0 && long_param) begin
            kind = 5;
            len  = $urandom_range(57, 60);
         end else begin
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 8);
            // keep the item count near the budget
            if (len > budget - sent)
               len = budget - sent;
         end
         if (kind == 7)
            len = 1;
         for (n = 0; n < len; n++) begin
            s.db      = 8'($urandom_range(0, 255));
            s.pid     = 8'($urandom_range(0, 255));
            s.last    = (n == len - 1);
            s.typed   = 1'b0;
            s.exp_cmd = '0;
            if (kind <= 4)
               s.op = hrpf_pkg::OP_COLOR;
            else if (kind <= 6)
               s.op = hrpf_pkg::OP_PARAM;
            else if (kind == 7)
               s.op = $urandom_range(0, 1) ? hrpf_pkg::OP_BEGIN : hrpf_pkg::OP_END;
            else begin
               s.op   = hrpf_pkg::op_type'($urandom_range(0, 3));
               s.last = $urandom_range(0, 1);
            end
            send_item(s);
         end
         if (hold_off && sent == 0)
            wait_drained();
         sent += len;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      report_beat_type got;
      report_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.val = rsp_tdata[7:0];
         got.pos = rsp_tdata[13:8];
         got.fin = rsp_tlast;
         if (report_beat_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected transaction: byte %h index %0d end %b",
                        got.val, got.pos, got.fin);
         end else begin
            want = report_beat_q.pop_front();
            if (got.val !== want.val || got.pos !== want.pos || got.fin !== want.fin) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected byte %h index %0d end %b, got %h %0d %b",
                           want.val, want.pos, want.fin, got.val, got.pos, got.fin);
            end
         end
      end
   end

   initial begin : main_seq
      int i;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(directed_tbl); i++)
         send_item(directed_tbl[i]);
      wait_drained();

      set_commands(8'h00, 8'hFF, 8'h00);
      run_random(60, 1'b1, 1'b0, 1'b0);
      wait_drained();

      src_idle_pct  = 51;
      sink_idle_pct = 23;
      set_commands(8'hFF, 8'h00, 8'hFF);
      run_random(60, 1'b0, 1'b1, 1'b1);
      wait_drained();

      src_idle_pct  = 0;
      sink_idle_pct = 0;
      set_commands(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      run_random(12, 1'b0, 1'b0, 1'b0);
      wait_drained();

      if (fail_count == 0 && report_beat_q.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

[hid_report_packet_framer_core.f]
rtl/hrpf_pkg.sv
rtl/hrpf_ram.sv
rtl/hrpf_ctrl.sv
rtl/hrpf_dp.sv
rtl/hid_report_packet_framer_core.sv
bench/tb_top.sv
